### hdl/owm_pkg.sv
package owm_pkg;

  localparam int RESET_LOW_W  = 10;
  localparam int PRES_WAIT_W  = 8;
  localparam int RESET_TAIL_W = 10;
  localparam int SLOT_TIME_W  = 8;
  localparam int SHORT_LOW_W  = 4;
  localparam int CFG_DATA_W   = 10;
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_LOW  = 3'd0,
    CFG_PRES_WAIT  = 3'd1,
    CFG_RESET_TAIL = 3'd2,
    CFG_SLOT_TIME  = 3'd3,
    CFG_WR1_LOW    = 3'd4,
    CFG_RD_LOW     = 3'd5
  } cfg_idx_t;

  localparam logic [RESET_LOW_W-1:0]  RESET_LOW_DFLT  = 10'd480;
  localparam logic [PRES_WAIT_W-1:0]  PRES_WAIT_DFLT  = 8'd80;
  localparam logic [RESET_TAIL_W-1:0] RESET_TAIL_DFLT = 10'd400;
  localparam logic [SLOT_TIME_W-1:0]  SLOT_TIME_DFLT  = 8'd60;
  localparam logic [SHORT_LOW_W-1:0]  WR1_LOW_DFLT    = 4'd1;
  localparam logic [SHORT_LOW_W-1:0]  RD_LOW_DFLT     = 4'd2;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_RESET = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    logic [RESET_LOW_W-1:0]  reset_low_us;
    logic [PRES_WAIT_W-1:0]  presence_wait_us;
    logic [RESET_TAIL_W-1:0] reset_tail_us;
    logic [SLOT_TIME_W-1:0]  slot_time_us;
    logic [SHORT_LOW_W-1:0]  write_one_low_us;
    logic [SHORT_LOW_W-1:0]  read_low_us;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] write_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic       rejected;
  } res_t;

endpackage

### hdl/owm_if.sv
interface owm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] write_byte;
  logic       line_level;

  modport source (output valid, output action, output write_byte, output line_level,
                  input ready);
  modport sink (input valid, input action, input write_byte, input line_level,
                output ready);
endinterface

interface owm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_byte;
  logic       rejected;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output read_byte, output rejected, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input presence, input read_byte, input rejected, output ready);
endinterface

### hdl/owm_cfg.sv
module owm_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  we,
  input  logic [owm_pkg::CFG_IDX_W-1:0]         index,
  input  logic [owm_pkg::CFG_DATA_W-1:0]        wdata,
  output owm_pkg::cfg_regs_t                    regs
);
  import owm_pkg::*;

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.reset_low_us     <= RESET_LOW_DFLT;
      regs_r.presence_wait_us <= PRES_WAIT_DFLT;
      regs_r.reset_tail_us    <= RESET_TAIL_DFLT;
      regs_r.slot_time_us     <= SLOT_TIME_DFLT;
      regs_r.write_one_low_us <= WR1_LOW_DFLT;
      regs_r.read_low_us      <= RD_LOW_DFLT;
    end else if (we) begin
      unique case (cfg_idx_t'(index))
        CFG_RESET_LOW:  regs_r.reset_low_us     <= wdata[RESET_LOW_W-1:0];
        CFG_PRES_WAIT:  regs_r.presence_wait_us <= wdata[PRES_WAIT_W-1:0];
        CFG_RESET_TAIL: regs_r.reset_tail_us    <= wdata[RESET_TAIL_W-1:0];
        CFG_SLOT_TIME:  regs_r.slot_time_us     <= wdata[SLOT_TIME_W-1:0];
        CFG_WR1_LOW:    regs_r.write_one_low_us <= wdata[SHORT_LOW_W-1:0];
        CFG_RD_LOW:     regs_r.read_low_us      <= wdata[SHORT_LOW_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

### hdl/owm_seq.sv
module owm_seq #(
  parameter int DELAY_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  owm_pkg::item_t     item,
  input  owm_pkg::cfg_regs_t cfg,
  output owm_pkg::res_t      res
);
  import owm_pkg::*;

  localparam int CMP_W = (DELAY_BITS > RESET_LOW_W) ? DELAY_BITS : RESET_LOW_W;
  localparam logic [DELAY_BITS-1:0] CNT_MAX = {DELAY_BITS{1'b1}};

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_RST_LOW  = 6'b000010,
    PH_RST_WAIT = 6'b000100,
    PH_RST_TAIL = 6'b001000,
    PH_SLOT_LOW = 6'b010000,
    PH_SLOT_REL = 6'b100000
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [DELAY_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [2:0]            bit_r, bit_nxt;
  logic [7:0]            shift_r, shift_nxt, shift_smp;
  action_t               op_r, op_nxt;
  logic                  pres_r, pres_nxt;
  logic [7:0]            rdres_r, rdres_nxt;

  action_t               act;
  logic [7:0]            low_len, tail_len;
  logic [RESET_LOW_W-1:0] target;
  logic                  reached, done, rej;

  assign act = action_t'(item.action);

  always_comb begin
    if (op_r == ACT_READ)
      low_len = {4'd0, cfg.read_low_us};
    else if (shift_r[0])
      low_len = {4'd0, cfg.write_one_low_us};
    else
      low_len = cfg.slot_time_us;
    tail_len = (cfg.slot_time_us > low_len) ? (cfg.slot_time_us - low_len) : 8'd1;
  end

  always_comb begin
    unique case (phase_r)
      PH_RST_LOW:  target = cfg.reset_low_us;
      PH_RST_WAIT: target = {2'd0, cfg.presence_wait_us};
      PH_RST_TAIL: target = cfg.reset_tail_us;
      PH_SLOT_LOW: target = {2'd0, low_len};
      PH_SLOT_REL: target = {2'd0, tail_len};
      default:     target = '0;
    endcase
  end

  // saturating count; hitting the ceiling also ends the phase
  assign cnt_inc = (cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  assign reached = (CMP_W'(cnt_inc) >= CMP_W'(target)) || (cnt_inc == CNT_MAX);

  // read slot samples on the first released tick
  assign shift_smp = (op_r == ACT_READ && cnt_inc == DELAY_BITS'(1))
                     ? {item.line_level, shift_r[7:1]} : shift_r;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    op_nxt    = op_r;
    pres_nxt  = pres_r;
    rdres_nxt = rdres_r;
    done      = 1'b0;
    rej       = 1'b0;
    if (act != ACT_TICK) begin
      if (phase_r != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        op_nxt  = act;
        cnt_nxt = '0;
        bit_nxt = '0;
        if (act == ACT_RESET) begin
          phase_nxt = PH_RST_LOW;
        end else begin
          shift_nxt = (act == ACT_WRITE) ? item.write_byte : 8'd0;
          phase_nxt = PH_SLOT_LOW;
        end
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_RST_LOW: begin
          cnt_nxt = cnt_inc;
          if (reached) begin
            phase_nxt = PH_RST_WAIT;
            cnt_nxt   = '0;
          end
        end
        PH_RST_WAIT: begin
          cnt_nxt = cnt_inc;
          if (reached) begin
            pres_nxt = ~item.line_level;
            cnt_nxt  = '0;
            if (cfg.reset_tail_us == '0) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              phase_nxt = PH_RST_TAIL;
            end
          end
        end
        PH_RST_TAIL: begin
          cnt_nxt = cnt_inc;
          if (reached) begin
            phase_nxt = PH_IDLE;
            cnt_nxt   = '0;
            done      = 1'b1;
          end
        end
        PH_SLOT_LOW: begin
          cnt_nxt = cnt_inc;
          if (reached) begin
            phase_nxt = PH_SLOT_REL;
            cnt_nxt   = '0;
          end
        end
        PH_SLOT_REL: begin
          cnt_nxt   = cnt_inc;
          shift_nxt = shift_smp;
          if (reached) begin
            if (op_r == ACT_WRITE)
              shift_nxt = {1'b0, shift_smp[7:1]};
            cnt_nxt = '0;
            if (bit_r == 3'd7) begin
              if (op_r == ACT_READ)
                rdres_nxt = shift_smp;
              bit_nxt   = '0;
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = PH_SLOT_LOW;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      op_r    <= ACT_TICK;
      pres_r  <= 1'b0;
      rdres_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      op_r    <= op_nxt;
      pres_r  <= pres_nxt;
      rdres_r <= rdres_nxt;
    end
  end

  assign res.drive_low = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_SLOT_LOW);
  assign res.busy_res  = (phase_nxt != PH_IDLE);
  assign res.done_res  = done;
  assign res.presence  = pres_nxt;
  assign res.read_byte = rdres_nxt;
  assign res.rejected  = rej;

endmodule

### hdl/one_wire_bus_master.sv
// 1-Wire bus master stepped by one-microsecond tick words. Each input word is
// a tick (with the sampled bus level) or a start command (reset/presence, byte
// write, byte read, LSB first); every word yields exactly one result word with
// the bus drive level to hold until the next word, busy, done, presence, the
// last read byte and a rejected flag for a start given while busy. Throughput
// is one word per clock unless the result port stalls; each word passes an
// input register and the sequencer's state update into the result register.
// The user must write the timing registers through the cfg port only while
// idle (not enforced); DELAY_BITS sets the saturating tick counter width.
module one_wire_bus_master #(
  parameter int DELAY_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  owm_in_if.sink                         in_word,
  owm_out_if.source                      out_word,
  input  logic                           cfg_we,
  input  logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import owm_pkg::*;

  cfg_regs_t cfg;
  item_t     item_r;
  logic      in_v_r, out_v_r;
  res_t      res, res_r;
  logic      step;

  owm_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .regs  (cfg)
  );

  // the held word moves into the result register whenever that slot frees up
  assign step          = in_v_r && (!out_v_r || out_word.ready);
  assign in_word.ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_word.ready) begin
      in_v_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.ready && in_word.valid) begin
      item_r.action     <= in_word.action;
      item_r.write_byte <= in_word.write_byte;
      item_r.line_level <= in_word.line_level;
    end
  end

  owm_seq #(
    .DELAY_BITS (DELAY_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_word.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_word.valid     = out_v_r;
  assign out_word.drive_low = res_r.drive_low;
  assign out_word.busy_res  = res_r.busy_res;
  assign out_word.done_res  = res_r.done_res;
  assign out_word.presence  = res_r.presence;
  assign out_word.read_byte = res_r.read_byte;
  assign out_word.rejected  = res_r.rejected;

endmodule

### sim/tb.sv
module tb;
  import owm_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_RST_LOW,
    SEQ_RST_WAIT,
    SEQ_RST_TAIL,
    SEQ_SLOT_LOW,
    SEQ_SLOT_REL
  } seq_phase_t;

  typedef enum int {LINE_LOW, LINE_HIGH, LINE_RAND} line_mode_t;

  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam int LONG_HOLD = 400;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_WORDS = 400;
  localparam int WORDS_PER_SETTING = 100;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  owm_in_if in_if();
  owm_out_if out_if();

  one_wire_bus_master u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_word(in_if),
    .out_word(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // sequencer mirror
  cfg_regs_t tcfg;
  seq_phase_t sq_phase;
  logic [CNT_W-1:0] sq_ticks;
  logic [2:0] sq_bit;
  logic [7:0] sq_shift;
  action_t sq_op;
  logic sq_present;
  logic [7:0] sq_read;

  res_t due_status[$];
  int n_words_sent = 0;
  int n_mismatch = 0;
  bit bursts_on = 1'b1;
  int hold_requests = 0;
  int hold_served = 0;
  int stall_left = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic void clear_master();
    tcfg.reset_low_us = RESET_LOW_DFLT;
    tcfg.presence_wait_us = PRES_WAIT_DFLT;
    tcfg.reset_tail_us = RESET_TAIL_DFLT;
    tcfg.slot_time_us = SLOT_TIME_DFLT;
    tcfg.write_one_low_us = WR1_LOW_DFLT;
    tcfg.read_low_us = RD_LOW_DFLT;
    sq_phase = SEQ_IDLE;
    sq_ticks = '0;
    sq_bit = '0;
    sq_shift = '0;
    sq_op = ACT_TICK;
    sq_present = 1'b0;
    sq_read = '0;
  endfunction

  // saturating count; hitting saturation ends the phase too
  function automatic bit count_hits(int unsigned target);
    if (sq_ticks != CNT_SAT) sq_ticks++;
    return (sq_ticks >= target) || (sq_ticks == CNT_SAT);
  endfunction

  function automatic int unsigned slot_low_len();
    if (sq_op == ACT_READ) return tcfg.read_low_us;
    return sq_shift[0] ? tcfg.write_one_low_us : tcfg.slot_time_us;
  endfunction

  function automatic int unsigned slot_tail_len();
    int unsigned low;
    low = slot_low_len();
    return (tcfg.slot_time_us > low) ? tcfg.slot_time_us - low : 1;
  endfunction

  function automatic bit advance_tick(logic line);
    int unsigned tail;
    bit fin;
    fin = 1'b0;
    case (sq_phase)
      SEQ_RST_LOW: begin
        if (count_hits(tcfg.reset_low_us)) begin
          sq_phase = SEQ_RST_WAIT;
          sq_ticks = '0;
        end
      end
      SEQ_RST_WAIT: begin
        if (count_hits(tcfg.presence_wait_us)) begin
          sq_present = ~line;
          sq_ticks = '0;
          if (tcfg.reset_tail_us == 0) begin
            sq_phase = SEQ_IDLE;
            return 1'b1;
          end
          sq_phase = SEQ_RST_TAIL;
        end
      end
      SEQ_RST_TAIL: begin
        if (count_hits(tcfg.reset_tail_us)) begin
          sq_phase = SEQ_IDLE;
          sq_ticks = '0;
          return 1'b1;
        end
      end
      SEQ_SLOT_LOW: begin
        if (count_hits(slot_low_len())) begin
          sq_phase = SEQ_SLOT_REL;
          sq_ticks = '0;
        end
      end
      SEQ_SLOT_REL: begin
        tail = slot_tail_len();
        fin = count_hits(tail);
        // read samples on the first released tick
        if (sq_op == ACT_READ && sq_ticks == 1) sq_shift = {line, sq_shift[7:1]};
        if (fin) begin
          if (sq_op == ACT_WRITE) sq_shift = sq_shift >> 1;
          sq_ticks = '0;
          if (sq_bit == 3'd7) begin
            if (sq_op == ACT_READ) sq_read = sq_shift;
            sq_bit = '0;
            sq_phase = SEQ_IDLE;
            return 1'b1;
          end
          sq_bit = sq_bit + 3'd1;
          sq_phase = SEQ_SLOT_LOW;
        end
      end
      default: sq_phase = SEQ_IDLE;
    endcase
    return 1'b0;
  endfunction

  function automatic res_t step_master(item_t w);
    res_t r;
    logic done;
    logic rej;
    done = 1'b0;
    rej = 1'b0;
    if (w.action == ACT_TICK) begin
      if (sq_phase != SEQ_IDLE) done = advance_tick(w.line_level);
    end else if (sq_phase != SEQ_IDLE) begin
      rej = 1'b1;
    end else begin
      sq_op = action_t'(w.action);
      sq_ticks = '0;
      sq_bit = '0;
      if (w.action == ACT_RESET) begin
        sq_phase = SEQ_RST_LOW;
      end else begin
        sq_shift = (w.action == ACT_WRITE) ? w.write_byte : 8'h00;
        sq_phase = SEQ_SLOT_LOW;
      end
    end
    r.drive_low = (sq_phase == SEQ_RST_LOW) || (sq_phase == SEQ_SLOT_LOW);
    r.busy_res = (sq_phase != SEQ_IDLE);
    r.done_res = done;
    r.presence = sq_present;
    r.read_byte = sq_read;
    r.rejected = rej;
    return r;
  endfunction

  function automatic cfg_regs_t make_timing(int rl, int pw, int rt, int st, int w1, int rd);
    cfg_regs_t c;
    c.reset_low_us = rl[RESET_LOW_W-1:0];
    c.presence_wait_us = pw[PRES_WAIT_W-1:0];
    c.reset_tail_us = rt[RESET_TAIL_W-1:0];
    c.slot_time_us = st[SLOT_TIME_W-1:0];
    c.write_one_low_us = w1[SHORT_LOW_W-1:0];
    c.read_low_us = rd[SHORT_LOW_W-1:0];
    return c;
  endfunction

  function automatic cfg_regs_t rand_timing();
    return make_timing($urandom_range(0, 10), $urandom_range(0, 8), $urandom_range(0, 10),
                       $urandom_range(0, 10), $urandom_range(0, 15), $urandom_range(0, 15));
  endfunction

  function automatic logic pick_line(line_mode_t mode);
    case (mode)
      LINE_LOW:  return 1'b0;
      LINE_HIGH: return 1'b1;
      default:   return 1'($urandom);
    endcase
  endfunction

  // valid stays up after a word is taken; it only drops for a gap or a drain
  task automatic send_word(action_t act, logic [7:0] wbyte, logic line);
    item_t w;
    w.action = act;
    w.write_byte = wbyte;
    w.line_level = line;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.action <= w.action;
    in_if.write_byte <= w.write_byte;
    in_if.line_level <= w.line_level;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    due_status.push_back(step_master(w));
    n_words_sent++;
  endtask

  task automatic finish_op(line_mode_t mode, bit noisy);
    while (sq_phase != SEQ_IDLE) begin
      if (noisy && $urandom_range(0, 15) == 0)
        send_word(action_t'($urandom_range(1, 3)), 8'($urandom), pick_line(mode));
      else
        send_word(ACT_TICK, 8'($urandom), pick_line(mode));
    end
  endtask

  task automatic run_op(action_t act, logic [7:0] data, line_mode_t mode, bit noisy);
    send_word(act, data, pick_line(mode));
    finish_op(mode, noisy);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (due_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // narrow registers get junk in the unused upper data bits
  task automatic load_timing(cfg_regs_t c);
    drain_results();
    write_reg(CFG_RESET_LOW, c.reset_low_us);
    write_reg(CFG_PRES_WAIT, {2'($urandom), c.presence_wait_us});
    write_reg(CFG_RESET_TAIL, c.reset_tail_us);
    write_reg(CFG_SLOT_TIME, {2'($urandom), c.slot_time_us});
    write_reg(CFG_WR1_LOW, {6'($urandom), c.write_one_low_us});
    write_reg(CFG_RD_LOW, {6'($urandom), c.read_low_us});
    write_reg(CFG_IDX_SPARE, 10'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    tcfg = c;
  endtask

  task automatic test_default_timing();
    send_word(ACT_TICK, 8'h00, 1'b0);
    send_word(ACT_TICK, 8'hFF, 1'b1);
    run_op(ACT_WRITE, 8'hA5, LINE_RAND, 1'b0);
  endtask

  task automatic test_reset_presence();
    load_timing(make_timing(3, 2, 2, 6, 2, 3));
    run_op(ACT_RESET, 8'h00, LINE_LOW, 1'b0);
    run_op(ACT_RESET, 8'hFF, LINE_HIGH, 1'b0);
    run_op(ACT_RESET, 8'($urandom), LINE_RAND, 1'b0);
  endtask

  task automatic test_byte_write();
    run_op(ACT_WRITE, 8'h00, LINE_RAND, 1'b0);
    run_op(ACT_WRITE, 8'hFF, LINE_RAND, 1'b0);
    run_op(ACT_WRITE, 8'h5A, LINE_RAND, 1'b0);
  endtask

  task automatic test_byte_read();
    run_op(ACT_READ, 8'h00, LINE_HIGH, 1'b0);
    run_op(ACT_READ, 8'hFF, LINE_LOW, 1'b0);
    run_op(ACT_READ, 8'($urandom), LINE_RAND, 1'b0);
  endtask

  task automatic test_busy_reject();
    send_word(ACT_WRITE, 8'h3C, 1'b1);
    send_word(ACT_READ, 8'hFF, 1'b0);
    send_word(ACT_TICK, 8'h00, 1'b1);
    send_word(ACT_RESET, 8'h00, 1'b0);
    send_word(ACT_WRITE, 8'hC3, 1'b1);
    finish_op(LINE_RAND, 1'b0);
    send_word(ACT_RESET, 8'h00, 1'b0);
    send_word(ACT_READ, 8'h81, 1'b1);
    finish_op(LINE_LOW, 1'b0);
  endtask

  task automatic test_zero_timing();
    // all-zero registers: every phase lasts a single tick, no reset tail
    load_timing(make_timing(0, 0, 0, 0, 0, 0));
    run_op(ACT_RESET, 8'h00, LINE_LOW, 1'b0);
    run_op(ACT_WRITE, 8'hC3, LINE_RAND, 1'b0);
    run_op(ACT_READ, 8'h00, LINE_RAND, 1'b0);
    // low pulse longer than the slot: tail clamps to one tick
    load_timing(make_timing(1, 1, 1, 2, 4, 4));
    run_op(ACT_WRITE, 8'hFF, LINE_RAND, 1'b0);
    run_op(ACT_READ, 8'h00, LINE_RAND, 1'b0);
  endtask

  task automatic test_long_timing();
    // 1023 equals the counter's saturation value
    load_timing(make_timing(1023, 2, 0, 255, 15, 15));
    run_op(ACT_RESET, 8'h00, LINE_LOW, 1'b0);
  endtask

  task automatic test_backpressure();
    load_timing(make_timing(4, 3, 4, 10, 3, 2));
    hold_requests++;
    run_op(ACT_WRITE, 8'($urandom), LINE_RAND, 1'b0);
    send_word(ACT_READ, 8'h00, 1'b1);
    repeat (5) send_word(ACT_TICK, 8'($urandom), 1'($urandom));
    drain_results();
    finish_op(LINE_RAND, 1'b1);
  endtask

  task automatic test_random_traffic();
    int first;
    int setting_start;
    first = n_words_sent;
    while (n_words_sent - first < RANDOM_WORDS) begin
      load_timing(rand_timing());
      setting_start = n_words_sent;
      while (n_words_sent - setting_start < WORDS_PER_SETTING &&
             n_words_sent - first < RANDOM_WORDS) begin
        if ($urandom_range(0, 7) == 0) send_word(ACT_TICK, 8'($urandom), 1'($urandom));
        run_op(action_t'($urandom_range(1, 3)), 8'($urandom),
               line_mode_t'($urandom_range(0, 2)), 1'b1);
      end
    end
  endtask

  task automatic test_steady_stream();
    drain_results();
    bursts_on = 1'b0;
    load_timing(rand_timing());
    run_op(ACT_READ, 8'($urandom), LINE_RAND, 1'b1);
    run_op(ACT_WRITE, 8'($urandom), LINE_RAND, 1'b1);
    run_op(ACT_RESET, 8'($urandom), LINE_RAND, 1'b1);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{drive_low: out_if.drive_low, busy_res: out_if.busy_res,
              done_res: out_if.done_res, presence: out_if.presence,
              read_byte: out_if.read_byte, rejected: out_if.rejected};
      if (due_status.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("%0t: result word %p with none expected", $time, got);
      end else begin
        want = due_status.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("%0t: expected %p, got %p", $time, want, got);
        end
      end
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    #16000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_TICK;
    in_if.write_byte = '0;
    in_if.line_level = 1'b1;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    clear_master();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_timing();
    test_reset_presence();
    test_byte_write();
    test_byte_read();
    test_busy_reject();
    test_zero_timing();
    test_long_timing();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();

    drain_results();
    repeat (8) @(posedge clk);
    if (n_mismatch == 0 && due_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
